@@ rtl/nv12_scaled_rgb_converter_top_assert.svh @@
// Assertion macros shared by the checker of the NV12 scaled RGB converter.
`ifndef NV12_SCALED_RGB_CONVERTER_TOP_ASSERT_SVH
`define NV12_SCALED_RGB_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NV12SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NV12SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nv12sc_pkg.sv @@
// Types, constants and helper functions of the NV12 scaled RGB converter.
`default_nettype none

package nv12sc_pkg;

	localparam int CFG_W     = 13;
	localparam int COORD_W   = 12;
	localparam int PIX_W     = 8;
	localparam int STAT_W    = 2;
	localparam int REG_IDX_W = 3;
	localparam int YSIZE_W   = 2 * CFG_W;
	localparam int PROD_W    = COORD_W + CFG_W;
	localparam int ADDR_W    = 28;
	localparam int PRD_W     = 18;

	localparam logic [CFG_W-1:0] CFG_RESET = 13'd64;

	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd3;

	localparam logic signed [PRD_W-1:0] COEF_RV    = 18'sd359;
	localparam logic signed [PRD_W-1:0] COEF_GU    = 18'sd88;
	localparam logic signed [PRD_W-1:0] COEF_GV    = 18'sd183;
	localparam logic signed [PRD_W-1:0] COEF_BU    = 18'sd454;
	localparam logic signed [PRD_W-1:0] CHROMA_OFS = 18'sd128;
	localparam logic signed [PRD_W-1:0] PIX_MAX    = 18'sd255;

	typedef struct packed {
		logic               func;
		logic               frame_start;
		logic [PIX_W-1:0]   data_byte;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
	} nv12sc_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]  red;
		logic [PIX_W-1:0]  green;
		logic [PIX_W-1:0]  blue;
		logic [STAT_W-1:0] status;
	} nv12sc_out_t;

	// Step strobes from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic size;
		logic prod_x;
		logic prod_y;
		logic div_go;
		logic addr;
		logic sum;
		logic bound;
		logic rd_u;
		logic rd_v;
		logic mult;
		logic conv;
	} nv12sc_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic chk_fail;
		logic bnd_fail;
		logic div_done;
	} nv12sc_stat_t;

	function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [PRD_W-1:0] n);
		logic [PIX_W-1:0] r;
		if (n < 0) begin
			r = '0;
		end else if (n > PIX_MAX) begin
			r = PIX_MAX[PIX_W-1:0];
		end else begin
			r = n[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/nv12sc_div.sv @@
// Restoring divider that retires one quotient bit per clock cycle.
`default_nettype none

module nv12sc_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quo,
	output logic                  done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;

	// The numerator shifts out of the top of quo_q while quotient bits enter below.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/nv12sc_dp.sv @@
// Datapath: registers, frame store, coordinate dividers and color conversion.
`default_nettype none

module nv12sc_dp #(
	parameter int FRAME_BYTES = 65536
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire nv12sc_pkg::nv12sc_cmd_t             cmd,
	input  wire nv12sc_pkg::nv12sc_in_t              item,
	input  wire logic                                cfg_we,
	input  wire logic [nv12sc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [nv12sc_pkg::CFG_W-1:0]        cfg_data,
	output nv12sc_pkg::nv12sc_stat_t                 stat,
	output nv12sc_pkg::nv12sc_out_t                  result,
	output logic                                     result_valid
);

	localparam int AW    = $clog2(FRAME_BYTES);
	localparam int CW    = $clog2(FRAME_BYTES + 1);
	localparam int NEEDW = nv12sc_pkg::YSIZE_W + 1;
	localparam int CMP_W = (CW > NEEDW) ? CW : NEEDW;
	localparam int CFW   = nv12sc_pkg::CFG_W;
	localparam int ADW   = nv12sc_pkg::ADDR_W;
	localparam int PW    = nv12sc_pkg::PRD_W;

	// Configuration registers.
	logic [CFW-1:0] src_w_q, src_h_q, stride_q, out_w_q, out_h_q;

	// Frame store and its fill count.
	logic [nv12sc_pkg::PIX_W-1:0] mem [FRAME_BYTES];
	logic [nv12sc_pkg::PIX_W-1:0] rd_q;
	logic [AW-1:0]                rd_addr;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                load_base;
	logic                         load_ok;
	logic                         do_load;

	// Fetch working registers.
	logic [nv12sc_pkg::COORD_W-1:0] ox_q, oy_q;
	logic [nv12sc_pkg::YSIZE_W-1:0] ysize_q;
	logic [nv12sc_pkg::PROD_W-1:0]  px_q, py_q, half_q;
	logic [nv12sc_pkg::PROD_W-1:0]  qx, qy;
	logic [CFW-1:0]                 sx, sy;
	logic [ADW-1:0]                 yaddr_q, uvaddr_q;
	logic [nv12sc_pkg::PIX_W-1:0]   y_q, u_q;
	logic signed [PW-1:0]           pr_q, pg_q, pb_q;
	logic signed [PW-1:0]           du, dv, ys;
	logic signed [PW-1:0]           r_sum, g_sum, b_sum;
	logic [NEEDW-1:0]               need;
	logic                           chk_short, chk_range;
	logic                           div_done_x, div_done_y;

	nv12sc_pkg::nv12sc_out_t res_d, res_q;
	logic                    res_set, res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= nv12sc_pkg::CFG_RESET;
			src_h_q  <= nv12sc_pkg::CFG_RESET;
			stride_q <= nv12sc_pkg::CFG_RESET;
			out_w_q  <= nv12sc_pkg::CFG_RESET;
			out_h_q  <= nv12sc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nv12sc_pkg::REG_SRC_WIDTH:   src_w_q  <= cfg_data;
				nv12sc_pkg::REG_SRC_HEIGHT:  src_h_q  <= cfg_data;
				nv12sc_pkg::REG_LINE_STRIDE: stride_q <= cfg_data;
				nv12sc_pkg::REG_OUT_WIDTH:   out_w_q  <= cfg_data;
				nv12sc_pkg::REG_OUT_HEIGHT:  out_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A frame start restarts the count; once full, further bytes are dropped.
	assign do_load   = cmd.accept && (item.func == nv12sc_pkg::FUNC_LOAD);
	assign load_base = item.frame_start ? '0 : cnt_q;
	assign load_ok   = load_base < CW'(FRAME_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_load) begin
			cnt_q <= load_ok ? (load_base + 1'b1) : load_base;
		end
	end

	always_comb begin
		if (cmd.rd_u) begin
			rd_addr = uvaddr_q[AW-1:0];
		end else if (cmd.rd_v) begin
			rd_addr = uvaddr_q[AW-1:0] + 1'b1;
		end else begin
			rd_addr = yaddr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_load && load_ok) begin
			mem[load_base[AW-1:0]] <= item.data_byte;
		end
		rd_q <= mem[rd_addr];
	end

	nv12sc_div #(
		.NUM_W(nv12sc_pkg::PROD_W),
		.DEN_W(CFW)
	) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.div_go),
		.num   (px_q),
		.den   (out_w_q),
		.quo   (qx),
		.done  (div_done_x)
	);

	nv12sc_div #(
		.NUM_W(nv12sc_pkg::PROD_W),
		.DEN_W(CFW)
	) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.div_go),
		.num   (py_q),
		.den   (out_h_q),
		.quo   (qy),
		.done  (div_done_y)
	);

	// The quotient stays below the source size, so 13 bits hold it.
	assign sx = qx[CFW-1:0];
	assign sy = qy[CFW-1:0];

	assign need      = {1'b0, ysize_q} + NEEDW'(ysize_q >> 1);
	assign chk_short = CMP_W'(cnt_q) < CMP_W'(need);
	assign chk_range = ({1'b0, ox_q} >= out_w_q) || ({1'b0, oy_q} >= out_h_q);

	assign stat.chk_fail = chk_short || chk_range;
	assign stat.bnd_fail = (yaddr_q >= ADW'(FRAME_BYTES)) ||
		((uvaddr_q + 1'b1) >= ADW'(FRAME_BYTES));
	assign stat.div_done = div_done_x && div_done_y;

	assign du = PW'($signed({1'b0, u_q})) - nv12sc_pkg::CHROMA_OFS;
	assign dv = PW'($signed({1'b0, rd_q})) - nv12sc_pkg::CHROMA_OFS;
	assign ys = PW'($signed({1'b0, y_q}));

	assign r_sum = ys + (pr_q >>> 8);
	assign g_sum = ys - (pg_q >>> 8);
	assign b_sum = ys + (pb_q >>> 8);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ox_q <= item.out_x;
			oy_q <= item.out_y;
		end
		if (cmd.size) begin
			ysize_q <= stride_q * src_h_q;
		end
		if (cmd.prod_x) begin
			px_q <= ox_q * src_w_q;
		end
		if (cmd.prod_y) begin
			py_q <= oy_q * src_h_q;
		end
		// Luma row sy splits into twice the chroma row plus the odd line.
		if (cmd.addr) begin
			half_q <= sy[CFW-1:1] * stride_q;
		end
		if (cmd.sum) begin
			yaddr_q  <= ADW'({half_q, 1'b0}) + ADW'(sy[0] ? stride_q : '0) + ADW'(sx);
			uvaddr_q <= ADW'(ysize_q) + ADW'(half_q) + ADW'({sx[CFW-1:1], 1'b0});
		end
		if (cmd.rd_u) begin
			y_q <= rd_q;
		end
		if (cmd.rd_v) begin
			u_q <= rd_q;
		end
		if (cmd.mult) begin
			pr_q <= dv * nv12sc_pkg::COEF_RV;
			pg_q <= du * nv12sc_pkg::COEF_GU + dv * nv12sc_pkg::COEF_GV;
			pb_q <= du * nv12sc_pkg::COEF_BU;
		end
	end

	always_comb begin
		res_d   = '0;
		res_set = 1'b0;
		if (cmd.prod_y && stat.chk_fail) begin
			res_set      = 1'b1;
			res_d.status = chk_short ? nv12sc_pkg::STAT_SHORT : nv12sc_pkg::STAT_RANGE;
		end else if (cmd.bound && stat.bnd_fail) begin
			res_set      = 1'b1;
			res_d.status = nv12sc_pkg::STAT_BEYOND;
		end else if (cmd.conv) begin
			res_set      = 1'b1;
			res_d.red    = nv12sc_pkg::clamp_pix(r_sum);
			res_d.green  = nv12sc_pkg::clamp_pix(g_sum);
			res_d.blue   = nv12sc_pkg::clamp_pix(b_sum);
			res_d.status = nv12sc_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_set;
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			res_q <= res_d;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

`default_nettype wire

@@ rtl/nv12sc_ctrl.sv @@
// Controller state machine that sequences the steps of a pixel fetch.
`default_nettype none

module nv12sc_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     func,
	input  wire nv12sc_pkg::nv12sc_stat_t stat,
	output logic                          busy,
	output nv12sc_pkg::nv12sc_cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIZE,
		ST_PROD_X,
		ST_PROD_Y,
		ST_DIV_GO,
		ST_DIV,
		ST_ADDR,
		ST_SUM,
		ST_BOUND,
		ST_RD_U,
		ST_RD_V,
		ST_MULT,
		ST_CONV
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && (func == nv12sc_pkg::FUNC_FETCH)) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE:   state_q <= ST_PROD_X;
				ST_PROD_X: state_q <= ST_PROD_Y;
				ST_PROD_Y: state_q <= stat.chk_fail ? ST_IDLE : ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR:   state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_BOUND;
				ST_BOUND:  state_q <= stat.bnd_fail ? ST_IDLE : ST_RD_U;
				ST_RD_U:   state_q <= ST_RD_V;
				ST_RD_V:   state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_CONV;
				ST_CONV:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = start && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE:   ;
			ST_SIZE:   cmd.size   = 1'b1;
			ST_PROD_X: cmd.prod_x = 1'b1;
			ST_PROD_Y: cmd.prod_y = 1'b1;
			ST_DIV_GO: cmd.div_go = 1'b1;
			ST_DIV:    ;
			ST_ADDR:   cmd.addr   = 1'b1;
			ST_SUM:    cmd.sum    = 1'b1;
			ST_BOUND:  cmd.bound  = 1'b1;
			ST_RD_U:   cmd.rd_u   = 1'b1;
			ST_RD_V:   cmd.rd_v   = 1'b1;
			ST_MULT:   cmd.mult   = 1'b1;
			ST_CONV:   cmd.conv   = 1'b1;
			default:   ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/nv12_scaled_rgb_converter_top.sv @@
// Top level of the NV12 frame store with nearest-neighbor scaling RGB output.
`default_nettype none

// The block holds one NV12 frame of up to FRAME_BYTES bytes and returns scaled,
// BT.601 converted RGB pixels from it. An item is taken at a rising edge with
// start high and busy low. A load item (func = 0) writes one byte at the current
// fill count and is done in that same cycle, so loads stream at one item per
// cycle with busy staying low; frame_start restarts the count at zero, and bytes
// beyond the store are dropped. A fetch item (func = 1) raises busy for the
// whole fetch: two 25-bit by 13-bit restoring dividers, one bit per cycle, map
// the output coordinate onto the source, and three reads of the frame store
// follow. A fetch that finds the payload too short or the coordinate out of
// range ends after the PROD_Y step, and one whose address falls beyond the
// store ends after the BOUND step. Every fetch gives exactly one result, shown
// on result for one cycle with result_valid high, in the first cycle after busy
// falls. The receiver cannot stall, so it must take the result in that cycle.
// On any status other than ok the color fields are zero. Configuration registers
// are written through cfg_we, cfg_index and cfg_data; they must be written only
// while the block is idle, which the block itself does not enforce. The store
// has no clearing pass, and a fetch may read only bytes loaded since reset.

module nv12_scaled_rgb_converter_top #(
	parameter int FRAME_BYTES = 65536
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire nv12sc_pkg::nv12sc_in_t           item,
	output logic                                  result_valid,
	output nv12sc_pkg::nv12sc_out_t               result,
	input  wire logic                             cfg_we,
	input  wire logic [nv12sc_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [nv12sc_pkg::CFG_W-1:0]     cfg_data
);

	nv12sc_pkg::nv12sc_cmd_t  cmd;
	nv12sc_pkg::nv12sc_stat_t stat;

	// The controller only sequences; all data stays in the datapath.
	nv12sc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (item.func),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	nv12sc_dp #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stat        (stat),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

`default_nettype wire

@@ rtl/nv12sc_chk.sv @@
// Port-level checker for the NV12 scaled RGB converter and its bind statement.
`default_nettype none
`include "nv12_scaled_rgb_converter_top_assert.svh"

module nv12sc_chk (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire nv12sc_pkg::nv12sc_in_t  item,
	input wire logic                    result_valid,
	input wire nv12sc_pkg::nv12sc_out_t result
);

	`NV12SC_ASSERT_NOW(a_result_when_idle, clk, arst_n, result_valid, !busy, "result while busy")
	`NV12SC_ASSERT_NOW(a_result_after_fetch, clk, arst_n, result_valid, $past(busy), "result without a fetch")
	`NV12SC_ASSERT_NEXT(a_load_no_busy, clk, arst_n, start && !busy && (item.func == nv12sc_pkg::FUNC_LOAD), !busy && !result_valid, "load item raised busy or gave a result")
	`NV12SC_ASSERT_NEXT(a_fetch_busy, clk, arst_n, start && !busy && (item.func == nv12sc_pkg::FUNC_FETCH), busy, "fetch item did not raise busy")
	`NV12SC_ASSERT_NOW(a_error_black, clk, arst_n, result_valid && (result.status != nv12sc_pkg::STAT_OK), (result.red == '0) && (result.green == '0) && (result.blue == '0), "error result with color")

endmodule

bind nv12_scaled_rgb_converter_top nv12sc_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);

`default_nettype wire

@@ tb/nv12sc_pixel_checker.sv @@
// Checker that predicts and compares the pixels of the NV12 scaled RGB converter.
module nv12sc_pixel_checker #(
	parameter int STORE_BYTES = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  nv12sc_pkg::nv12sc_in_t           item,
	input  logic                             result_valid,
	input  nv12sc_pkg::nv12sc_out_t          result,
	input  logic                             cfg_we,
	input  logic [nv12sc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [nv12sc_pkg::CFG_W-1:0]     cfg_data,
	output int                               mismatches,
	output int                               pending
);
	import nv12sc_pkg::*;

	logic [PIX_W-1:0] store [STORE_BYTES];
	int loaded;
	logic [CFG_W-1:0] src_w, src_h, stride, dst_w, dst_h;
	nv12sc_out_t pixel_q [$];

	function automatic logic [PIX_W-1:0] to_pixel(input int n);
		if (n < 0) begin
			return '0;
		end
		if (n > 255) begin
			return 8'd255;
		end
		return n[PIX_W-1:0];
	endfunction

	// Nearest-neighbor lookup followed by the integer BT.601 conversion.
	function automatic nv12sc_out_t predict_pixel(input nv12sc_in_t it);
		nv12sc_out_t px;
		longint y_size, need, sx, sy, y_addr, uv_addr;
		int luma, cb, cr;
		px = '0;
		y_size = longint'(stride) * longint'(src_h);
		need = y_size + y_size / 2;
		if (longint'(loaded) < need) begin
			px.status = STAT_SHORT;
		end else if (it.out_x >= dst_w || it.out_y >= dst_h) begin
			px.status = STAT_RANGE;
		end else begin
			sx = longint'(it.out_x) * longint'(src_w) / longint'(dst_w);
			sy = longint'(it.out_y) * longint'(src_h) / longint'(dst_h);
			y_addr = sy * longint'(stride) + sx;
			uv_addr = y_size + (sy / 2) * longint'(stride) + (sx - sx % 2);
			if (y_addr >= STORE_BYTES || uv_addr + 1 >= STORE_BYTES) begin
				px.status = STAT_BEYOND;
			end else begin
				luma = int'(store[y_addr]);
				cb = int'(store[uv_addr]) - 128;
				cr = int'(store[uv_addr + 1]) - 128;
				// Arithmetic shifts on signed ints round toward minus infinity.
				px.red = to_pixel(luma + ((359 * cr) >>> 8));
				px.green = to_pixel(luma - ((88 * cb + 183 * cr) >>> 8));
				px.blue = to_pixel(luma + ((454 * cb) >>> 8));
				px.status = STAT_OK;
			end
		end
		return px;
	endfunction

	task automatic flag_pixel(input string what, input nv12sc_out_t want);
		if (mismatches < 10) begin
			$display("%0t %s: expected r=%0d g=%0d b=%0d status=%0d, got r=%0d g=%0d b=%0d status=%0d",
				$time, what, want.red, want.green, want.blue, want.status,
				result.red, result.green, result.blue, result.status);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		nv12sc_out_t want;
		if (!arst_n) begin
			loaded = 0;
			src_w = CFG_RESET;
			src_h = CFG_RESET;
			stride = CFG_RESET;
			dst_w = CFG_RESET;
			dst_h = CFG_RESET;
			pixel_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (result_valid) begin
				if (pixel_q.size() == 0) begin
					flag_pixel("unexpected pixel", '0);
				end else begin
					want = pixel_q.pop_front();
					if (result.red !== want.red || result.green !== want.green ||
						result.blue !== want.blue || result.status !== want.status) begin
						flag_pixel("pixel mismatch", want);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH: src_w = cfg_data;
					REG_SRC_HEIGHT: src_h = cfg_data;
					REG_LINE_STRIDE: stride = cfg_data;
					REG_OUT_WIDTH: dst_w = cfg_data;
					REG_OUT_HEIGHT: dst_h = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (item.func == FUNC_LOAD) begin
					if (item.frame_start) begin
						loaded = 0;
					end
					if (loaded < STORE_BYTES) begin
						store[loaded] = item.data_byte;
						loaded++;
					end
				end else begin
					pixel_q.push_back(predict_pixel(item));
				end
			end
			pending <= pixel_q.size();
		end
	end

endmodule

@@ tb/nv12_scaled_rgb_converter_top_tb.sv @@
// Testbench top of the NV12 scaled RGB converter: stimulus, timeout and verdict.
module nv12_scaled_rgb_converter_top_tb;
	import nv12sc_pkg::*;

	localparam int STORE_BYTES = 65536;
	// The cycle limit leaves a wide margin over the length of a full run.
	localparam int CYCLE_LIMIT = 300000;
	// Longer than any fetch keeps the block busy, so this covers any tail.
	localparam int SETTLE_CYCLES = 40;
	// Register indexes above the last defined register are decoded as nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
	// Frames larger than this are not reloaded during the random part.
	localparam int RELOAD_MAX = 32;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	nv12sc_in_t item;
	logic result_valid;
	nv12sc_out_t result;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int cycles = 0;
	// Percentage of cycles in which the sender holds back before the next item.
	int idle_pct;
	// The fill count the block should hold; used only to shape the stimulus.
	int fill_count;
	// Loads only ever advance from address zero, so the entries written since
	// reset always form the prefix of the store below this mark.
	int written;
	// Geometry last written to the block, used only to shape the stimulus.
	int cur_sw, cur_sh, cur_st, cur_ow, cur_oh;

	nv12_scaled_rgb_converter_top #(
		.FRAME_BYTES(STORE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	nv12sc_pixel_checker #(
		.STORE_BYTES(STORE_BYTES)
	) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// A hung handshake or a lost pixel ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** nv12_scaled_rgb_converter_top: FAILED **");
			$finish;
		end
	end

	// Presents one item and returns right after the edge that accepted it. Start
	// is left high, so the caller either presents the next item or lowers start
	// in the same step, never both.
	task automatic drive_item(input nv12sc_in_t it);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
	endtask

	// A load item; the coordinate fields carry random noise that must be ignored.
	task automatic load_byte(input logic restart, input logic [PIX_W-1:0] value);
		nv12sc_in_t it;
		it.func = FUNC_LOAD;
		it.frame_start = restart;
		it.data_byte = value;
		it.out_x = COORD_W'($urandom);
		it.out_y = COORD_W'($urandom);
		drive_item(it);
		if (restart) begin
			fill_count = 0;
		end
		if (fill_count < STORE_BYTES) begin
			fill_count++;
		end
		if (fill_count > written) begin
			written = fill_count;
		end
	endtask

	// A fetch item; the load fields carry random noise that must be ignored.
	task automatic fetch_pixel(input int x, input int y);
		nv12sc_in_t it;
		it.func = FUNC_FETCH;
		it.frame_start = 1'($urandom);
		it.data_byte = PIX_W'($urandom);
		it.out_x = x[COORD_W-1:0];
		it.out_y = y[COORD_W-1:0];
		drive_item(it);
	endtask

	// True when a fetch of this coordinate would get as far as reading the store
	// and one of its three bytes has never been loaded since reset.
	function automatic logic reads_unwritten(input int x, input int y);
		longint y_size, need, sx, sy, y_addr, uv_addr;
		logic hit;
		hit = 1'b0;
		y_size = longint'(cur_st) * longint'(cur_sh);
		need = y_size + y_size / 2;
		if (longint'(fill_count) >= need && x < cur_ow && y < cur_oh) begin
			sx = longint'(x) * longint'(cur_sw) / longint'(cur_ow);
			sy = longint'(y) * longint'(cur_sh) / longint'(cur_oh);
			y_addr = sy * longint'(cur_st) + sx;
			uv_addr = y_size + (sy / 2) * longint'(cur_st) + (sx - sx % 2);
			if (y_addr < STORE_BYTES && uv_addr + 1 < STORE_BYTES) begin
				hit = (y_addr >= written) || (uv_addr + 1 >= written);
			end
		end
		return hit;
	endfunction

	// Restarts the frame and streams the given number of random bytes into it.
	task automatic refill(input int count);
		for (int k = 0; k < count; k++) begin
			load_byte(k == 0, PIX_W'($urandom));
		end
	endtask

	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic write_config(input int sw, input int sh, input int st, input int ow,
		input int oh);
		cur_sw = sw;
		cur_sh = sh;
		cur_st = st;
		cur_ow = ow;
		cur_oh = oh;
		set_reg(REG_SRC_WIDTH, sw);
		set_reg(REG_SRC_HEIGHT, sh);
		set_reg(REG_LINE_STRIDE, st);
		set_reg(REG_OUT_WIDTH, ow);
		set_reg(REG_OUT_HEIGHT, oh);
		cfg_we <= 1'b0;
	endtask

	// Stops the sender and waits until every predicted pixel has come back. The
	// first edge lets the checker book an item accepted in this very step.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output coordinate: mostly inside the output frame, often right at its far
	// edge where the source addresses are largest, sometimes anywhere at all.
	function automatic int pick_coord(input int span);
		int roll, offset, c;
		roll = $urandom_range(0, 99);
		offset = $urandom_range(0, 3);
		if (span > 0 && roll < 65) begin
			c = $urandom_range(0, span - 1);
		end else if (span > 0 && roll < 80) begin
			c = span - 1 - offset;
			if (c < 0) begin
				c = 0;
			end
		end else begin
			c = $urandom_range(0, 4095);
		end
		return c;
	endfunction

	// One configuration phase. The frame is first made long enough for the new
	// geometry where the store can hold it, so that most fetches reach the
	// converter. The random mix then has fetches, single loads that extend the
	// frame, complete frame reloads and reloads that stop a few bytes short. A
	// fetch that would read bytes never loaded since reset becomes a load.
	task automatic run_phase(input int sw, input int sh, input int st, input int ow,
		input int oh, input int pct, input int count);
		int need, roll, shortfall, x, y;
		settle();
		write_config(sw, sh, st, ow, oh);
		need = st * sh + (st * sh) / 2;
		idle_pct = 0;
		if (need <= STORE_BYTES && fill_count < need) begin
			refill(need + $urandom_range(0, 2));
		end
		idle_pct = pct;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			shortfall = $urandom_range(1, 3);
			if (roll < 70) begin
				x = pick_coord(ow);
				y = pick_coord(oh);
				if (reads_unwritten(x, y)) begin
					load_byte(1'b0, PIX_W'($urandom));
				end else begin
					fetch_pixel(x, y);
				end
			end else if (roll < 92 || need > RELOAD_MAX) begin
				load_byte(1'b0, PIX_W'($urandom));
			end else if (roll < 97) begin
				refill(need + $urandom_range(0, 2));
			end else begin
				refill(need > shortfall ? need - shortfall : 1);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= '0;
		idle_pct = 0;
		fill_count = 0;
		written = 0;
		cur_sw = 64;
		cur_sh = 64;
		cur_st = 64;
		cur_ow = 64;
		cur_oh = 64;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to an undecoded index must leave every register alone.
		set_reg(REG_SPARE, $urandom_range(0, 8191));
		write_config(64, 64, 64, 64, 64);

		// Default geometry with nothing loaded: every fetch finds the payload too
		// short, even with the coordinate out of range.
		fetch_pixel(0, 0);
		fetch_pixel(63, 63);
		fetch_pixel(64, 0);
		fetch_pixel(0, 64);
		fetch_pixel(4095, 4095);

		// A tiny 2x2 frame, upscaled to 4x4, with hand-picked bytes that drive the
		// color math into both clamps.
		settle();
		write_config(2, 2, 2, 4, 4);
		load_byte(1'b1, 8'd255);
		load_byte(1'b0, 8'd0);
		load_byte(1'b0, 8'd0);
		// Three of six bytes: a short payload wins over the bad coordinate.
		fetch_pixel(5, 5);
		load_byte(1'b0, 8'd255);
		load_byte(1'b0, 8'd255);
		load_byte(1'b0, 8'd0);
		fetch_pixel(0, 0);
		fetch_pixel(2, 0);
		fetch_pixel(3, 3);
		fetch_pixel(4, 0);
		// Same frame again with the chroma pair swapped to the other extreme.
		load_byte(1'b1, 8'd0);
		load_byte(1'b0, 8'd255);
		load_byte(1'b0, 8'd255);
		load_byte(1'b0, 8'd0);
		load_byte(1'b0, 8'd0);
		load_byte(1'b0, 8'd255);
		fetch_pixel(0, 0);
		fetch_pixel(1, 2);
		fetch_pixel(3, 0);

		// Random phases over a range of geometries, each with its own sender idling.
		run_phase(4, 4, 4, 4, 4, 0, 30);
		run_phase(1, 1, 1, 1, 1, 71, 40);
		run_phase(7, 5, 8, 13, 9, 8, 40);
		// The largest geometry needs far more than the store holds: always short.
		run_phase(4096, 4096, 4096, 4096, 4096, 0, 30);
		// A zero output size turns every fetch into a range error.
		run_phase(2, 2, 2, 0, 5, 71, 30);
		run_phase(2, 2, 2, 5, 0, 8, 30);
		// Odd sizes put the last chroma pair past the end of the payload.
		run_phase(5, 3, 5, 9, 7, 8, 40);
		// Source wider than its stride, stretched to a single very wide line.
		run_phase(10, 6, 6, 4096, 1, 0, 40);
		run_phase(6, 8, 6, 5, 17, 71, 40);

		settle();
		if (mismatches == 0 && pending == 0) begin
			$display("** nv12_scaled_rgb_converter_top: PASSED **");
		end else begin
			$display("** nv12_scaled_rgb_converter_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/nv12sc_pkg.sv
rtl/nv12sc_div.sv
rtl/nv12sc_dp.sv
rtl/nv12sc_ctrl.sv
rtl/nv12_scaled_rgb_converter_top.sv
rtl/nv12sc_chk.sv
tb/nv12sc_pixel_checker.sv
tb/nv12_scaled_rgb_converter_top_tb.sv
